>>> rtl/core/tetg_pkg.sv
`default_nettype none

package tetg_pkg;

	// field and register widths
	localparam int IDX_W     = 10;
	localparam int CFG_W     = 11;
	localparam int MODE_W    = 3;
	localparam int REG_IDX_W = 2;
	localparam int GAIN_FRAC = 16;
	localparam int GAIN_W    = GAIN_FRAC + 1;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

	// sine taper datapath: Q30 phase and coefficients
	localparam int X_FRAC   = 30;
	localparam int COEF_W   = 31;
	localparam int SIN_STEPS = 5;
	localparam logic [COEF_W-1:0] SIN_COEF [SIN_STEPS+1] = '{
		31'd3864, 31'd172272, 31'd5026995, 31'd85569304, 31'd693598669, 31'd1686629713
	};
	localparam logic [COEF_W-1:0] SIN_CLAMP = COEF_W'(1) << X_FRAC;
	localparam int GAIN_SHIFT = X_FRAC - GAIN_FRAC;

	// ramp datapath
	localparam int RAMP_D = 2 * CFG_W;
	localparam int RAMP_Q = GAIN_FRAC + 1;

	// pipeline latencies, counted from the entry register
	localparam int SINE_LAT = X_FRAC + 1 + SIN_STEPS + 3;
	localparam int RAMP_LAT = 2 + RAMP_Q;

	// taper modes
	localparam logic [MODE_W-1:0] MODE_BOTH     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_START    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_END      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_RAMP     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ZERO_END = 3'd5;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LENGTH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COUNT  = 2'd2;

	localparam logic [CFG_W-1:0] COUNT_RESET = 11'd1024;

	// which gain an item finally takes
	typedef enum logic [2:0] {
		SEL_UNITY,
		SEL_START,
		SEL_END,
		SEL_BOTH,
		SEL_RAMP,
		SEL_ZERO
	} sel_t;

endpackage

`default_nettype wire

>>> rtl/core/tetg_div.sv
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
// needs dividend < divisor * 2**QBITS
module tetg_div
	import tetg_pkg::*;
#(
	parameter int QBITS = 30,
	parameter int DBITS = 11
) (
	input  wire logic                   clk,
	input  wire logic [QBITS+DBITS-1:0] dividend,
	input  wire logic [DBITS-1:0]       divisor,
	output logic      [QBITS-1:0]       quotient
);

	logic [DBITS-1:0] rem_s [QBITS];
	logic [QBITS-1:0] low_s [QBITS];
	logic [DBITS-1:0] dvs_s [QBITS];
	logic [QBITS-1:0] quo_s [QBITS];

	logic [DBITS-1:0] rem_in [QBITS];
	logic [QBITS-1:0] low_in [QBITS];
	logic [DBITS-1:0] dvs_in [QBITS];
	logic [QBITS-1:0] quo_in [QBITS];
	logic [DBITS:0]   trial  [QBITS];
	logic [DBITS:0]   diff   [QBITS];
	logic [QBITS-1:0] take;

	always_comb begin
		rem_in[0] = dividend[QBITS+DBITS-1:QBITS];
		low_in[0] = dividend[QBITS-1:0];
		dvs_in[0] = divisor;
		quo_in[0] = '0;
		for (int i = 1; i < QBITS; i++) begin
			rem_in[i] = rem_s[i-1];
			low_in[i] = low_s[i-1];
			dvs_in[i] = dvs_s[i-1];
			quo_in[i] = quo_s[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < QBITS; i++) begin
			trial[i] = {rem_in[i], low_in[i][QBITS-1]};
			diff[i]  = trial[i] - {1'b0, dvs_in[i]};
			take[i]  = trial[i] >= {1'b0, dvs_in[i]};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QBITS; i++) begin
			rem_s[i] <= take[i] ? diff[i][DBITS-1:0] : trial[i][DBITS-1:0];
			low_s[i] <= {low_in[i][QBITS-2:0], 1'b0};
			dvs_s[i] <= dvs_in[i];
			quo_s[i] <= {quo_in[i][QBITS-2:0], take[i]};
		end
	end

	assign quotient = quo_s[QBITS-1];

endmodule

`default_nettype wire

>>> rtl/core/tetg_sine.sv
`default_nettype none

// sin^2(pi*k/(2*len)) in Q1.16
module tetg_sine
	import tetg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [CFG_W-1:0]  k,
	input  wire logic [CFG_W-1:0]  len,
	output logic      [GAIN_W-1:0] gain
);

	logic [X_FRAC+CFG_W-1:0] dividend;
	logic [X_FRAC-1:0]       xq;
	logic [2*X_FRAC-1:0]     xx;

	// x = round(k * 2^30 / len); len/2 never reaches bit 30
	assign dividend = {k, X_FRAC'(len >> 1)};

	tetg_div #(
		.QBITS(X_FRAC),
		.DBITS(CFG_W)
	) u_div (
		.clk     (clk),
		.dividend(dividend),
		.divisor (len),
		.quotient(xq)
	);

	assign xx = xq * xq;

	// Horner steps, one multiply per stage
	logic [X_FRAC-1:0]        hx_s  [SIN_STEPS+1];
	logic [X_FRAC-1:0]        hx2_s [SIN_STEPS];
	logic [COEF_W-1:0]        hp_s  [SIN_STEPS];
	logic [COEF_W-1:0]        pin   [SIN_STEPS];
	logic [X_FRAC+COEF_W-1:0] mul   [SIN_STEPS];

	always_comb begin
		pin[0] = SIN_COEF[0];
		for (int j = 1; j < SIN_STEPS; j++) begin
			pin[j] = hp_s[j-1];
		end
		for (int j = 0; j < SIN_STEPS; j++) begin
			mul[j] = hx2_s[j] * pin[j];
		end
	end

	always_ff @(posedge clk) begin
		hx_s[0]  <= xq;
		hx2_s[0] <= xx[2*X_FRAC-1:X_FRAC];
		for (int j = 0; j < SIN_STEPS; j++) begin
			hp_s[j]   <= SIN_COEF[j+1] - mul[j][X_FRAC+COEF_W-1:X_FRAC];
			hx_s[j+1] <= hx_s[j];
		end
		for (int j = 0; j < SIN_STEPS - 1; j++) begin
			hx2_s[j+1] <= hx2_s[j];
		end
	end

	// s = x * p, clamped to one
	logic [X_FRAC+COEF_W-1:0] sm;
	logic [COEF_W-1:0]        s_raw;
	logic [COEF_W-1:0]        s_s37;
	logic [2*COEF_W-1:0]      ss;
	logic [COEF_W-1:0]        sq_s38;
	logic [COEF_W-1:0]        gsum;
	logic [GAIN_W-1:0]        g_raw;
	logic [GAIN_W-1:0]        gain_s39;

	assign sm    = hx_s[SIN_STEPS] * hp_s[SIN_STEPS-1];
	assign s_raw = sm[X_FRAC+COEF_W-1:X_FRAC];
	assign ss    = s_s37 * s_s37;
	assign gsum  = sq_s38 + (COEF_W'(1) << (GAIN_SHIFT - 1));
	assign g_raw = gsum[GAIN_SHIFT +: GAIN_W];

	always_ff @(posedge clk) begin
		s_s37    <= (s_raw > SIN_CLAMP) ? SIN_CLAMP : s_raw;
		sq_s38   <= ss[X_FRAC+COEF_W-1:X_FRAC];
		gain_s39 <= (g_raw > GAIN_ONE) ? GAIN_ONE : g_raw;
	end

	assign gain = gain_s39;

endmodule

`default_nettype wire

>>> rtl/core/tetg_ramp.sv
`default_nettype none

// round(num^2 * 2^16 / den^2)
module tetg_ramp
	import tetg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic [CFG_W-1:0]  num,
	input  wire logic [CFG_W-1:0]  den,
	output logic      [GAIN_W-1:0] gain
);

	logic [RAMP_D-1:0]        nsq_s1;
	logic [RAMP_D-1:0]        dsq_s1;
	logic [RAMP_Q+RAMP_D-1:0] dvd_s2;
	logic [RAMP_D-1:0]        dvs_s2;

	always_ff @(posedge clk) begin
		nsq_s1 <= num * num;
		dsq_s1 <= den * den;
		dvd_s2 <= {nsq_s1, GAIN_FRAC'(0)} + (RAMP_Q+RAMP_D)'(dsq_s1 >> 1);
		dvs_s2 <= dsq_s1;
	end

	// num <= den keeps the quotient within RAMP_Q bits
	tetg_div #(
		.QBITS(RAMP_Q),
		.DBITS(RAMP_D)
	) u_div (
		.clk     (clk),
		.dividend(dvd_s2),
		.divisor (dvs_s2),
		.quotient(gain)
	);

endmodule

`default_nettype wire

>>> rtl/core/trace_edge_taper_gain.sv
`default_nettype none

// channel   | ports                                   | handshake
// ----------+-----------------------------------------+------------------------------
// item in   | trace_index, sample_in                  | start && !busy at clk rise
// result    | sample_out, gain_applied                | done, one cycle, no backpress
// config    | cfg_index, cfg_wdata                    | cfg_we at clk rise
//
// One item per clock cycle, sustained. Each item passes through the entry
// stage, the 30-stage divider for the taper phase, nine polynomial and
// squaring stages, and four stages for gain select and sample scaling.
// busy never rises, the pipeline does not stall, and done carries each
// result for exactly one cycle. arst_n clears the registers to mode 0,
// length 0, count 1024 and drops all valid bits.
module trace_edge_taper_gain
	import tetg_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// item in
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic        [IDX_W-1:0]       trace_index,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	// result
	output logic                               done,
	output logic signed      [SAMPLE_BITS-1:0] sample_out,
	output logic             [GAIN_W-1:0]      gain_applied,
	// config
	input  wire logic                          cfg_we,
	input  wire logic        [REG_IDX_W-1:0]   cfg_index,
	input  wire logic        [CFG_W-1:0]       cfg_wdata
);

	localparam int PAD  = SINE_LAT - RAMP_LAT;
	localparam int PW   = SAMPLE_BITS + GAIN_W + 1;
	localparam int AB_W = 2 * GAIN_W + 1;

	// ---------------------------------------------------------------
	// config registers
	// ---------------------------------------------------------------
	logic [MODE_W-1:0] mode_q;
	logic [CFG_W-1:0]  length_q;
	logic [CFG_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BOTH;
			length_q <= '0;
			count_q  <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_wdata[MODE_W-1:0];
				REG_LENGTH: length_q <= cfg_wdata;
				REG_COUNT:  count_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// entry: region decode against the clamped taper length
	// ---------------------------------------------------------------
	logic             accept;
	logic [CFG_W-1:0] len;
	logic [CFG_W-1:0] idx_x;
	logic [CFG_W:0]   end_sum;
	logic             in_start;
	logic             in_end;
	logic             idx_lt_n;
	logic [CFG_W-1:0] k_end;
	logic [CFG_W-1:0] den;
	sel_t             sel;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign len      = (length_q < count_q) ? length_q : count_q;
	assign idx_x    = CFG_W'(trace_index);
	assign end_sum  = {1'b0, idx_x} + {1'b0, len};
	assign in_start = idx_x < len;
	assign idx_lt_n = idx_x < count_q;
	assign in_end   = idx_lt_n && (end_sum >= {1'b0, count_q});
	assign k_end    = count_q - CFG_W'(1) - idx_x;
	assign den      = count_q - CFG_W'(1) - len;

	always_comb begin
		sel = SEL_UNITY;
		unique case (mode_q)
			MODE_BOTH: begin
				if (in_start && in_end) begin
					sel = SEL_BOTH;
				end else if (in_start) begin
					sel = SEL_START;
				end else if (in_end) begin
					sel = SEL_END;
				end
			end
			MODE_START: begin
				if (in_start) begin
					sel = SEL_START;
				end
			end
			MODE_END: begin
				if (in_end) begin
					sel = SEL_END;
				end
			end
			MODE_RAMP: begin
				// zero divisor leaves unity
				if (!in_start && idx_lt_n && (den != '0)) begin
					sel = SEL_RAMP;
				end
			end
			MODE_ZERO_END: begin
				if (in_end) begin
					sel = SEL_ZERO;
				end
			end
			default: sel = SEL_UNITY;
		endcase
	end

	logic                          vld_s1;
	sel_t                          sel_s1;
	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic [CFG_W-1:0]              kst_s1;
	logic [CFG_W-1:0]              kend_s1;
	logic [CFG_W-1:0]              len_s1;
	logic [CFG_W-1:0]              den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1  <= sel;
		smp_s1  <= sample_in;
		kst_s1  <= idx_x;
		kend_s1 <= k_end;
		len_s1  <= len;
		den_s1  <= den;
	end

	// ---------------------------------------------------------------
	// gain units: start taper, end taper, ramp
	// ---------------------------------------------------------------
	logic [GAIN_W-1:0] ga;
	logic [GAIN_W-1:0] gb;
	logic [GAIN_W-1:0] gr;

	tetg_sine u_sine_start (
		.clk (clk),
		.k   (kst_s1),
		.len (len_s1),
		.gain(ga)
	);

	tetg_sine u_sine_end (
		.clk (clk),
		.k   (kend_s1),
		.len (len_s1),
		.gain(gb)
	);

	tetg_ramp u_ramp (
		.clk (clk),
		.num (kend_s1),
		.den (den_s1),
		.gain(gr)
	);

	// ramp result lines up with the taper result
	logic [GAIN_W-1:0] gr_s [PAD];

	always_ff @(posedge clk) begin
		gr_s[0] <= gr;
		for (int i = 1; i < PAD; i++) begin
			gr_s[i] <= gr_s[i-1];
		end
	end

	// item sideband travels alongside the gain units
	logic [SINE_LAT-1:0]           vld_s;
	sel_t                          sel_s [SINE_LAT];
	logic signed [SAMPLE_BITS-1:0] smp_s [SINE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[SINE_LAT-2:0], vld_s1};
		end
	end

	always_ff @(posedge clk) begin
		sel_s[0] <= sel_s1;
		smp_s[0] <= smp_s1;
		for (int i = 1; i < SINE_LAT; i++) begin
			sel_s[i] <= sel_s[i-1];
			smp_s[i] <= smp_s[i-1];
		end
	end

	// ---------------------------------------------------------------
	// gain combine and sample scaling
	// ---------------------------------------------------------------
	logic                          vld_s41;
	sel_t                          sel_s41;
	logic signed [SAMPLE_BITS-1:0] smp_s41;
	logic [GAIN_W-1:0]             ga_s41;
	logic [GAIN_W-1:0]             gb_s41;
	logic [GAIN_W-1:0]             gr_s41;
	logic [2*GAIN_W-1:0]           ab_s41;

	logic                          vld_s42;
	logic signed [SAMPLE_BITS-1:0] smp_s42;
	logic [GAIN_W-1:0]             gain_s42;

	logic                          vld_s43;
	logic [GAIN_W-1:0]             gain_s43;
	logic signed [PW-1:0]          prod_s43;

	logic                          done_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [GAIN_W-1:0]             gain_q;

	logic [AB_W-1:0]               ab_rnd;
	logic [GAIN_W+1:0]             ab_g;
	logic [GAIN_W-1:0]             gain_sel;
	logic signed [PW-1:0]          prod_rnd;

	// both tapers: product of the two gains, rounded
	assign ab_rnd = {1'b0, ab_s41} + (AB_W'(1) << (GAIN_FRAC - 1));
	assign ab_g   = ab_rnd[GAIN_FRAC +: GAIN_W + 2];

	always_comb begin
		case (sel_s41)
			SEL_START: gain_sel = ga_s41;
			SEL_END:   gain_sel = gb_s41;
			SEL_BOTH:  gain_sel = (ab_g > (GAIN_W+2)'(GAIN_ONE)) ? GAIN_ONE
			                                                    : ab_g[GAIN_W-1:0];
			SEL_RAMP:  gain_sel = (gr_s41 > GAIN_ONE) ? GAIN_ONE : gr_s41;
			SEL_ZERO:  gain_sel = '0;
			default:   gain_sel = GAIN_ONE;
		endcase
	end

	// half rounds up: add half, then floor
	assign prod_rnd = prod_s43 + (PW'(1) << (GAIN_FRAC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s41 <= 1'b0;
			vld_s42 <= 1'b0;
			vld_s43 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s41 <= vld_s[SINE_LAT-1];
			vld_s42 <= vld_s41;
			vld_s43 <= vld_s42;
			done_q  <= vld_s43;
		end
	end

	always_ff @(posedge clk) begin
		sel_s41  <= sel_s[SINE_LAT-1];
		smp_s41  <= smp_s[SINE_LAT-1];
		ga_s41   <= ga;
		gb_s41   <= gb;
		gr_s41   <= gr_s[PAD-1];
		ab_s41   <= ga * gb;

		smp_s42  <= smp_s41;
		gain_s42 <= gain_sel;

		gain_s43 <= gain_s42;
		prod_s43 <= smp_s42 * $signed({1'b0, gain_s42});

		sample_q <= prod_rnd[GAIN_FRAC +: SAMPLE_BITS];
		gain_q   <= gain_s43;
	end

	assign done         = done_q;
	assign sample_out   = sample_q;
	assign gain_applied = gain_q;

endmodule

`default_nettype wire
